### design/dfcc_pkg.sv
// shared types, constants and the crc-32 byte update for the packet deframer
package dfcc_pkg;

    localparam logic [4:0]  HEADER_BYTES = 5'd16;
    localparam logic [4:0]  OFS_VERSION  = 5'd2;
    localparam logic [4:0]  OFS_KIND     = 5'd3;
    localparam logic [4:0]  OFS_SEQ_END  = 5'd8;
    localparam logic [4:0]  OFS_CHECK    = 5'd12;

    localparam logic [24:0] COUNT_MAX    = '1;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam logic [15:0] MAGIC_RESET   = 16'd0;
    localparam logic [7:0]  VERSION_RESET = 8'd1;
    localparam logic [23:0] MAXLEN_RESET  = 24'd4096;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_MAXLEN  = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_CRC       = 3'd6
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [23:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_data;
        logic        frame_done;
        t_status     frame_status;
        logic [7:0]  message_kind;
        logic [31:0] sequence_number;
    } t_result;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/packet_deframer_crc32_check.sv
// top level of the packet deframer with crc-32 check
// Takes one frame byte per clock while full is low; the header is captured and the
// byte-wide crc-32 update runs in the same cycle, so a byte's result (forwarded payload
// byte or end-of-frame status) enters a four-entry result queue at the acceptance edge and
// can be popped from the next cycle on. Sustained rate is one byte per cycle; input stalls
// only when the result queue is full. Configuration writes are always ready.
module packet_deframer_crc32_check
    import dfcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_frame_end,
    output logic        empty,
    input  logic        pop,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_data,
    output logic        o_frame_done,
    output logic [2:0]  o_frame_status,
    output logic [7:0]  o_message_kind,
    output logic [31:0] o_sequence_number,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic       w_accept;
    logic       w_pop;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_head;
    t_cfg_write w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    assign w_accept = push && !full;
    assign w_pop    = pop && !empty;

    dfcc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_accept      (w_accept),
        .i_stream_byte (i_stream_byte),
        .i_frame_end   (i_frame_end),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    dfcc_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_res_valid),
        .i_wr_data (w_res),
        .i_rd_en   (w_pop),
        .o_rd_data (w_head),
        .o_empty   (empty),
        .o_full    (full)
    );

    assign o_payload_valid   = w_head.payload_valid;
    assign o_payload_data    = w_head.payload_data;
    assign o_frame_done      = w_head.frame_done;
    assign o_frame_status    = w_head.frame_status;
    assign o_message_kind    = w_head.message_kind;
    assign o_sequence_number = w_head.sequence_number;

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_end) |-> w_res_valid)
        else $error("frame end transfer produced no result");

    a_short_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.frame_done && w_res.frame_status == ST_SHORT)
        |-> (w_res.sequence_number == 32'd0 && w_res.message_kind == 8'd0))
        else $error("short header result carries header fields");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !full)
        else $error("result written into a full queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

endmodule

### design/dfcc_parser.sv
// front end: header capture, crc update, payload gating and frame status
module dfcc_parser
    import dfcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_write i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_stream_byte,
    input  logic       i_frame_end,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [15:0] r_exp_magic;
    logic [7:0]  r_exp_version;
    logic [23:0] r_max_len;

    logic [4:0]  r_pos,      n_pos;
    logic [15:0] r_magic,    n_magic;
    logic [7:0]  r_version,  n_version;
    logic [7:0]  r_kind,     n_kind;
    logic [31:0] r_sequence, n_sequence;
    logic [31:0] r_length,   n_length;
    logic [31:0] r_check,    n_check;
    logic [31:0] r_crc,      n_crc;
    logic [24:0] r_count,    n_count;

    logic    fwd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= MAGIC_RESET;
            r_exp_version <= VERSION_RESET;
            r_max_len     <= MAXLEN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAGIC:   r_exp_magic   <= i_cfg.data[15:0];
                REG_VERSION: r_exp_version <= i_cfg.data[7:0];
                REG_MAXLEN:  r_max_len     <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_magic    = r_magic;
        n_version  = r_version;
        n_kind     = r_kind;
        n_sequence = r_sequence;
        n_length   = r_length;
        n_check    = r_check;
        n_crc      = r_crc;
        n_count    = r_count;
        fwd        = 1'b0;

        if (r_pos < HEADER_BYTES) begin
            if (r_pos < OFS_VERSION) begin
                n_magic = {r_magic[7:0], i_stream_byte};
            end else if (r_pos == OFS_VERSION) begin
                n_version = i_stream_byte;
            end else if (r_pos == OFS_KIND) begin
                n_kind = i_stream_byte;
            end else if (r_pos < OFS_SEQ_END) begin
                n_sequence = {r_sequence[23:0], i_stream_byte};
            end else if (r_pos < OFS_CHECK) begin
                n_length = {r_length[23:0], i_stream_byte};
            end else begin
                n_check = {r_check[23:0], i_stream_byte};
            end
            if (r_pos < OFS_CHECK) begin
                n_crc = crc32_byte(r_crc, i_stream_byte);
            end
            n_pos = r_pos + 5'd1;
        end else begin
            n_crc = crc32_byte(r_crc, i_stream_byte);
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 25'd1;
            end
            fwd = (r_magic == r_exp_magic) && (r_version == r_exp_version)
                && (r_length <= {8'd0, r_max_len})
                && ({7'd0, n_count} <= r_length);
        end

        if (n_pos < HEADER_BYTES) begin
            status = ST_SHORT;
        end else if (n_magic != r_exp_magic) begin
            status = ST_MAGIC;
        end else if (n_version != r_exp_version) begin
            status = ST_VERSION;
        end else if (n_length != {7'd0, n_count}) begin
            status = ST_LENGTH;
        end else if (n_length > {8'd0, r_max_len}) begin
            status = ST_TOO_LARGE;
        end else if (~n_crc != n_check) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end

        o_res_valid           = i_accept && (fwd || i_frame_end);
        o_res.payload_valid   = fwd;
        o_res.payload_data    = fwd ? i_stream_byte : 8'd0;
        o_res.frame_done      = i_frame_end;
        o_res.frame_status    = i_frame_end ? status : ST_OK;
        o_res.message_kind    = (i_frame_end && status != ST_SHORT) ? n_kind : 8'd0;
        o_res.sequence_number = (i_frame_end && status != ST_SHORT) ? n_sequence : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_frame_end)) begin
            r_pos      <= '0;
            r_magic    <= '0;
            r_version  <= '0;
            r_kind     <= '0;
            r_sequence <= '0;
            r_length   <= '0;
            r_check    <= '0;
            r_crc      <= CRC_INIT;
            r_count    <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_magic    <= n_magic;
            r_version  <= n_version;
            r_kind     <= n_kind;
            r_sequence <= n_sequence;
            r_length   <= n_length;
            r_check    <= n_check;
            r_crc      <= n_crc;
            r_count    <= n_count;
        end
    end

endmodule

### design/dfcc_result_queue.sv
// back end: small result queue that presents the oldest result to the consumer
module dfcc_result_queue
    import dfcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_result i_wr_data,
    input  logic    i_rd_en,
    output t_result o_rd_data,
    output logic    o_empty,
    output logic    o_full
);

    t_result r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: ;
            endcase
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));

endmodule
